// ----- src/basp_pkg.sv -----
// Shared types and constants for the build attribute stream parser.
// Used by basp_core, basp_out_fifo and build_attribute_stream_parser_unit.
package basp_pkg;

  typedef enum logic [3:0] {
    PH_FORMAT = 4'd0,
    PH_LENGTH = 4'd1,
    PH_VENDOR = 4'd2,
    PH_SUBTAG = 4'd3,
    PH_SUBLEN = 4'd4,
    PH_TAG    = 4'd5,
    PH_VALUE  = 4'd6,
    PH_STRING = 4'd7,
    PH_SKIP   = 4'd8
  } basp_phase_t;

  localparam logic [7:0]  FORMAT_LETTER  = 8'h41;
  localparam logic [31:0] MIN_LENGTH     = 32'd5;
  localparam logic [7:0]  FILE_SUBTAG    = 8'd1;
  localparam logic [63:0] STRING_TAG     = 64'd4;
  localparam logic [6:0]  ULEB_STEP      = 7'd7;
  localparam logic [6:0]  ULEB_LIMIT     = 7'd64;

  localparam logic KIND_ATTR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic        record_kind;
    logic [31:0] attr_tag;
    logic [63:0] attr_value;
    logic        has_string;
    logic [31:0] string_offset;
    logic [31:0] string_length;
    logic [31:0] attr_count;
    logic        end_of_run;
  } basp_rec_t;

  typedef struct packed {
    logic      attr_vld;
    logic      sum_vld;
    basp_rec_t attr;
    basp_rec_t sum;
  } basp_push_t;

endpackage

// ----- src/basp_core.sv -----
// Byte-at-a-time parser state and the combinational step for one item.
// Depends on basp_pkg for the phase type and the record structs.
module basp_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic [31:0]         total_size,
  input  logic                big_endian,
  output basp_pkg::basp_push_t push
);

  basp_pkg::basp_phase_t phase, phase_next;
  logic [31:0] pos, pos_next;
  logic [32:0] sec_end, sec_end_next;
  logic [32:0] sub_end, sub_end_next;
  logic [31:0] len_acc, len_acc_next;
  logic [1:0]  len_idx, len_idx_next;
  logic [63:0] uleb_acc, uleb_acc_next;
  logic [6:0]  uleb_shift, uleb_shift_next;
  logic [31:0] held_tag, held_tag_next;
  logic [31:0] str_start, str_start_next;
  logic [31:0] found_count, found_count_next;
  logic        halted, halted_next;

  logic [32:0] np;
  logic [31:0] len_new;
  logic [32:0] len_sum;
  logic        len_wrap;
  logic [32:0] len_end;
  logic [63:0] uleb_new;
  logic [6:0]  shift_plus;
  logic        uleb_cont;
  logic        uleb_broken;
  logic        at_sec_end;
  logic        in_sub;
  logic        ns_ok;
  logic        emit;
  logic [31:0] count_after;

  assign np          = {1'b0, pos} + 33'd1;
  assign len_new     = big_endian ? {len_acc[23:0], data_byte}
                                  : (len_acc | ({24'd0, data_byte} << {len_idx, 3'b000}));
  assign len_sum     = {1'b0, pos} + {1'b0, len_new};
  assign len_wrap    = len_sum < 33'd3;
  assign len_end     = len_sum - 33'd3;
  assign uleb_new    = uleb_acc | ({57'd0, data_byte[6:0]} << uleb_shift[5:0]);
  assign shift_plus  = uleb_shift + basp_pkg::ULEB_STEP;
  assign uleb_cont   = data_byte[7];
  assign in_sub      = np < sub_end;
  assign uleb_broken = uleb_cont && ((shift_plus >= basp_pkg::ULEB_LIMIT) || !in_sub);
  assign at_sec_end  = np >= sec_end;
  assign ns_ok       = ({1'b0, sec_end} + 34'd4) <= {2'b00, total_size};

  // Record emission for this byte.
  always_comb begin
    emit = 1'b0;
    if (!halted) begin
      case (phase)
        basp_pkg::PH_TAG:
          emit = !uleb_cont && (uleb_new == basp_pkg::STRING_TAG) && !in_sub;
        basp_pkg::PH_VALUE:
          emit = !uleb_cont;
        basp_pkg::PH_STRING:
          emit = (data_byte == 8'd0) || !in_sub;
        default:
          emit = 1'b0;
      endcase
    end
  end

  assign count_after = found_count + {31'd0, emit};

  always_comb begin
    push = '0;
    push.attr_vld = accept && emit;
    push.sum_vld  = accept && last_byte;
    push.attr.record_kind = basp_pkg::KIND_ATTR;
    push.attr.attr_tag    = (phase == basp_pkg::PH_TAG) ? uleb_new[31:0] : held_tag;
    push.attr.attr_value  = (phase == basp_pkg::PH_VALUE) ? uleb_new : 64'd0;
    if ((phase == basp_pkg::PH_STRING) && (data_byte == 8'd0)) begin
      push.attr.has_string    = 1'b1;
      push.attr.string_offset = str_start;
      push.attr.string_length = pos - str_start;
    end
    push.sum.record_kind = basp_pkg::KIND_SUMMARY;
    push.sum.attr_count  = count_after;
    push.sum.end_of_run  = 1'b1;
  end

  // Next state for one accepted byte.
  always_comb begin
    logic goto_loop;
    logic goto_end;
    logic goto_next;
    phase_next       = phase;
    pos_next         = pos;
    sec_end_next     = sec_end;
    sub_end_next     = sub_end;
    len_acc_next     = len_acc;
    len_idx_next     = len_idx;
    uleb_acc_next    = uleb_acc;
    uleb_shift_next  = uleb_shift;
    held_tag_next    = held_tag;
    str_start_next   = str_start;
    found_count_next = count_after;
    halted_next      = halted;
    goto_loop        = 1'b0;
    goto_end         = 1'b0;
    goto_next        = 1'b0;
    if (!halted) begin
      pos_next = pos + 32'd1;
      unique case (phase)
        basp_pkg::PH_FORMAT: begin
          if ((total_size < basp_pkg::MIN_LENGTH) || (data_byte != basp_pkg::FORMAT_LETTER)) begin
            halted_next = 1'b1;
          end else begin
            phase_next   = basp_pkg::PH_LENGTH;
            len_acc_next = '0;
            len_idx_next = '0;
          end
        end
        basp_pkg::PH_LENGTH: begin
          len_acc_next = len_new;
          if (len_idx != 2'd3) begin
            len_idx_next = len_idx + 2'd1;
          end else begin
            len_idx_next = '0;
            if (len_new < basp_pkg::MIN_LENGTH) begin
              halted_next = 1'b1;
            end else if (len_wrap || (len_end > {1'b0, total_size})) begin
              halted_next = 1'b1;
            end else begin
              sec_end_next = len_end;
              phase_next   = basp_pkg::PH_VENDOR;
            end
          end
        end
        basp_pkg::PH_VENDOR: begin
          if (data_byte != 8'd0) begin
            if (at_sec_end) begin
              halted_next = 1'b1;
            end
          end else if (!at_sec_end) begin
            phase_next = basp_pkg::PH_SUBTAG;
          end else begin
            goto_next = 1'b1;
          end
        end
        basp_pkg::PH_SUBTAG: begin
          if (data_byte == basp_pkg::FILE_SUBTAG) begin
            if (({1'b0, np} + 34'd4) > {1'b0, sec_end}) begin
              halted_next = 1'b1;
            end else begin
              phase_next   = basp_pkg::PH_SUBLEN;
              len_acc_next = '0;
              len_idx_next = '0;
            end
          end else begin
            goto_end = 1'b1;
          end
        end
        basp_pkg::PH_SUBLEN: begin
          len_acc_next = len_new;
          if (len_idx != 2'd3) begin
            len_idx_next = len_idx + 2'd1;
          end else begin
            len_idx_next = '0;
            if (len_wrap || (len_end > sec_end)) begin
              sub_end_next = sec_end;
            end else begin
              sub_end_next = len_end;
            end
            goto_loop = 1'b1;
          end
        end
        basp_pkg::PH_TAG: begin
          if (uleb_broken) begin
            goto_end = 1'b1;
          end else if (uleb_cont) begin
            uleb_acc_next   = uleb_new;
            uleb_shift_next = shift_plus;
          end else begin
            held_tag_next = uleb_new[31:0];
            if (uleb_new == basp_pkg::STRING_TAG) begin
              str_start_next = np[31:0];
              if (in_sub) begin
                phase_next = basp_pkg::PH_STRING;
              end else begin
                goto_end = 1'b1;
              end
            end else if (in_sub) begin
              phase_next      = basp_pkg::PH_VALUE;
              uleb_acc_next   = '0;
              uleb_shift_next = '0;
            end else begin
              goto_end = 1'b1;
            end
          end
        end
        basp_pkg::PH_VALUE: begin
          if (uleb_broken) begin
            goto_end = 1'b1;
          end else if (uleb_cont) begin
            uleb_acc_next   = uleb_new;
            uleb_shift_next = shift_plus;
          end else begin
            goto_loop = 1'b1;
          end
        end
        basp_pkg::PH_STRING: begin
          if (data_byte == 8'd0) begin
            goto_loop = 1'b1;
          end else if (!in_sub) begin
            goto_end = 1'b1;
          end
        end
        basp_pkg::PH_SKIP: begin
          if (at_sec_end) begin
            goto_next = 1'b1;
          end
        end
        default: begin
          halted_next = 1'b1;
        end
      endcase
      if (goto_loop) begin
        if (np < sub_end_next) begin
          phase_next      = basp_pkg::PH_TAG;
          uleb_acc_next   = '0;
          uleb_shift_next = '0;
        end else begin
          goto_end = 1'b1;
        end
      end
      if (goto_end) begin
        if (at_sec_end) begin
          goto_next = 1'b1;
        end else begin
          phase_next = basp_pkg::PH_SKIP;
        end
      end
      if (goto_next) begin
        if (ns_ok) begin
          phase_next   = basp_pkg::PH_LENGTH;
          len_acc_next = '0;
          len_idx_next = '0;
        end else begin
          halted_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      phase       <= basp_pkg::PH_FORMAT;
      pos         <= '0;
      sec_end     <= '0;
      sub_end     <= '0;
      len_acc     <= '0;
      len_idx     <= '0;
      uleb_acc    <= '0;
      uleb_shift  <= '0;
      held_tag    <= '0;
      str_start   <= '0;
      found_count <= '0;
      halted      <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      pos         <= pos_next;
      sec_end     <= sec_end_next;
      sub_end     <= sub_end_next;
      len_acc     <= len_acc_next;
      len_idx     <= len_idx_next;
      uleb_acc    <= uleb_acc_next;
      uleb_shift  <= uleb_shift_next;
      held_tag    <= held_tag_next;
      str_start   <= str_start_next;
      found_count <= found_count_next;
      halted      <= halted_next;
    end
  end

endmodule

// ----- src/basp_out_fifo.sv -----
// Small result queue that takes up to two records per cycle and hands out one.
// Depends on basp_pkg for the record structs and queue sizing.
module basp_out_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  basp_pkg::basp_push_t       push,
  input  logic                       pop,
  output logic                       in_ready,
  output logic                       out_valid,
  output basp_pkg::basp_rec_t        out_rec,
  output logic [basp_pkg::FIFO_CW-1:0] level
);

  basp_pkg::basp_rec_t mem [basp_pkg::FIFO_DEPTH];
  logic [basp_pkg::FIFO_AW-1:0] wr_ptr;
  logic [basp_pkg::FIFO_AW-1:0] rd_ptr;
  logic [basp_pkg::FIFO_CW-1:0] count;
  logic [1:0]                   n_push;
  logic                         do_pop;
  basp_pkg::basp_rec_t          first_rec;

  assign n_push    = {1'b0, push.attr_vld} + {1'b0, push.sum_vld};
  assign out_valid = count != '0;
  assign do_pop    = pop && out_valid;
  assign in_ready  = count <= basp_pkg::FIFO_CW'(basp_pkg::FIFO_DEPTH - 2);
  assign out_rec   = mem[rd_ptr];
  assign level     = count;
  assign first_rec = push.attr_vld ? push.attr : push.sum;

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr] <= first_rec;
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr + basp_pkg::FIFO_AW'(1)] <= push.sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + basp_pkg::FIFO_AW'(n_push);
      if (do_pop) begin
        rd_ptr <= rd_ptr + basp_pkg::FIFO_AW'(1);
      end
      count <= count + basp_pkg::FIFO_CW'(n_push) - basp_pkg::FIFO_CW'(do_pop);
    end
  end

endmodule

// ----- src/build_attribute_stream_parser_unit.sv -----
// Top level of the build attribute stream parser: configuration registers,
// parser core and result queue. Depends on basp_pkg, basp_core, basp_out_fifo.
//
//   channel  direction  handshake          payload
//   s        in         s_tvalid/s_tready  tdata: data_byte; tlast: last_byte
//   m        out        m_tvalid/m_tready  tdata: record fields; tuser: kind;
//                                          tlast: end_of_run
//   cfg      in         cfg_wen            cfg_addr index, cfg_wdata value
//
// One byte is parsed per cycle while s_tready is high; its records are written to the result queue, which feeds m.
// A byte is taken whenever the four-entry result queue has room for two records,
// so with m_tready held high the block takes a byte in every cycle.
// Reset (rst, synchronous) clears the parser state, the queue and both registers.
// A stall on m only holds s off once the queue has three or more records.
module build_attribute_stream_parser_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] attr_tag, [95:32] attr_value, [96] has_string, [128:97] string_offset,
  // [160:129] string_length, [192:161] attr_count, [199:193] zero
  output logic [199:0] m_tdata,
  output logic         m_tuser,   // [0] record_kind
  output logic         m_tlast,
  input  logic         cfg_wen,
  input  logic         cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  localparam logic CFG_TOTAL_SIZE = 1'b0;
  localparam logic CFG_BIG_ENDIAN = 1'b1;

  logic [31:0]          total_size;
  logic                 big_endian;
  logic                 in_accept;
  basp_pkg::basp_push_t push;
  basp_pkg::basp_rec_t  out_rec;
  logic [basp_pkg::FIFO_CW-1:0] level;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_size <= '0;
      big_endian <= 1'b0;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        CFG_TOTAL_SIZE: total_size <= cfg_wdata;
        CFG_BIG_ENDIAN: big_endian <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_accept = s_tvalid && s_tready;

  basp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_accept),
    .data_byte  (s_tdata),
    .last_byte  (s_tlast),
    .total_size (total_size),
    .big_endian (big_endian),
    .push       (push)
  );

  basp_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (m_tready),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_rec   (out_rec),
    .level     (level)
  );

  assign m_tdata = {7'd0, out_rec.attr_count, out_rec.string_length, out_rec.string_offset,
                    out_rec.has_string, out_rec.attr_value, out_rec.attr_tag};
  assign m_tuser = out_rec.record_kind;
  assign m_tlast = out_rec.end_of_run;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= basp_pkg::FIFO_CW'(basp_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  a_summary_out: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_tlast) |=> m_tvalid)
    else $error("summary record not queued");

  a_kind_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == m_tlast))
    else $error("record kind and end of run disagree");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty queue");

endmodule
